[sv/crpd_pkg.sv]
package crpd_pkg;

	localparam int ADDR_BITS_DEF = 22;
	localparam int COORD_W = 13;
	localparam int PITCH_W = 14;
	localparam int BASE_W = 22;
	localparam int DST_W = 22;
	localparam int PIX_W = 8;
	localparam int REQ_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 22;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONTENT_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_PITCH = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE = 2'd3;

	localparam logic [COORD_W-1:0] SRC_WIDTH_RST = 13'd320;
	localparam logic [COORD_W-1:0] CONTENT_HEIGHT_RST = 13'd200;
	localparam logic [PITCH_W-1:0] DST_PITCH_RST = 14'd640;
	localparam logic [BASE_W-1:0] FRAME_BASE_RST = 22'd0;

	localparam logic REQ_RECT = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_WRITE = 1'b1;
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef struct packed {
		logic [COORD_W-1:0] src_width;
		logic [COORD_W-1:0] content_height;
		logic [PITCH_W-1:0] dst_pitch;
		logic [BASE_W-1:0] frame_base;
	} crpd_cfg_t;

	typedef struct packed {
		logic is_pix;
		logic empty;
		logic [COORD_W-1:0] cw;
		logic [COORD_W-1:0] ch;
		logic [PIX_W-1:0] pixel;
	} crpd_cmd_t;

endpackage

[sv/crpd_front.sv]
module crpd_front #(
	parameter int ADDR_BITS = crpd_pkg::ADDR_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input crpd_pkg::crpd_cfg_t cfg,
	input logic in_valid,
	output logic in_stall,
	input logic req_type,
	input logic signed [crpd_pkg::REQ_W-1:0] rect_x,
	input logic signed [crpd_pkg::REQ_W-1:0] rect_y,
	input logic signed [crpd_pkg::REQ_W-1:0] rect_w,
	input logic signed [crpd_pkg::REQ_W-1:0] rect_h,
	input logic [crpd_pkg::PIX_W-1:0] pixel_in,
	output logic push,
	output crpd_pkg::crpd_cmd_t push_cmd,
	output logic [ADDR_BITS-1:0] push_addr,
	input logic q_full
);
	import crpd_pkg::*;

	logic en;

	logic v_s1, v_s2, v_s3, v_s4;
	logic type_s1, type_s2, type_s3, type_s4;
	logic [PIX_W-1:0] pix_s1, pix_s2, pix_s3, pix_s4;

	logic signed [REQ_W-1:0] x_s1, y_s1, w_s1, h_s1;

	logic [REQ_W-2:0] x_s2, y_s2;
	logic signed [REQ_W:0] w_s2, h_s2;

	logic empty_s3, empty_s4;
	logic [COORD_W-1:0] ox_s3, oy_s3, cw_s3, ch_s3;
	logic [COORD_W-1:0] ox_s4, cw_s4, ch_s4;
	logic [COORD_W+PITCH_W-1:0] prod_s4;

	logic signed [REQ_W:0] w_adj, h_adj;
	logic [REQ_W-2:0] x_adj, y_adj;
	logic signed [REQ_W+1:0] ex, ey, wc, hc;
	logic empty_c;

	assign en = !v_s4 || !q_full;
	assign in_stall = !en;
	assign push = v_s4 && !q_full;

	// A negative origin moves to zero and shrinks the size by the same amount.
	always_comb begin
		if (x_s1[REQ_W-1]) begin
			w_adj = (REQ_W+1)'(w_s1) + (REQ_W+1)'(x_s1);
			x_adj = '0;
		end else begin
			w_adj = (REQ_W+1)'(w_s1);
			x_adj = x_s1[REQ_W-2:0];
		end
		if (y_s1[REQ_W-1]) begin
			h_adj = (REQ_W+1)'(h_s1) + (REQ_W+1)'(y_s1);
			y_adj = '0;
		end else begin
			h_adj = (REQ_W+1)'(h_s1);
			y_adj = y_s1[REQ_W-2:0];
		end
	end

	// Right and bottom clip against the surface bounds.
	always_comb begin
		ex = $signed({3'b000, x_s2}) + (REQ_W+2)'(w_s2);
		ey = $signed({3'b000, y_s2}) + (REQ_W+2)'(h_s2);
		if (ex > $signed({5'b00000, cfg.src_width})) begin
			wc = $signed({5'b00000, cfg.src_width}) - $signed({3'b000, x_s2});
		end else begin
			wc = (REQ_W+2)'(w_s2);
		end
		if (ey > $signed({5'b00000, cfg.content_height})) begin
			hc = $signed({5'b00000, cfg.content_height}) - $signed({3'b000, y_s2});
		end else begin
			hc = (REQ_W+2)'(h_s2);
		end
		empty_c = wc[REQ_W+1] || (wc == '0) || hc[REQ_W+1] || (hc == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			type_s1 <= req_type;
			pix_s1 <= pixel_in;
			x_s1 <= rect_x;
			y_s1 <= rect_y;
			w_s1 <= rect_w;
			h_s1 <= rect_h;

			type_s2 <= type_s1;
			pix_s2 <= pix_s1;
			x_s2 <= x_adj;
			y_s2 <= y_adj;
			w_s2 <= w_adj;
			h_s2 <= h_adj;

			type_s3 <= type_s2;
			pix_s3 <= pix_s2;
			empty_s3 <= empty_c;
			ox_s3 <= x_s2[COORD_W-1:0];
			oy_s3 <= y_s2[COORD_W-1:0];
			cw_s3 <= wc[COORD_W-1:0];
			ch_s3 <= hc[COORD_W-1:0];

			type_s4 <= type_s3;
			pix_s4 <= pix_s3;
			empty_s4 <= empty_s3;
			ox_s4 <= ox_s3;
			cw_s4 <= cw_s3;
			ch_s4 <= ch_s3;
			prod_s4 <= (COORD_W+PITCH_W)'(oy_s3) * (COORD_W+PITCH_W)'(cfg.dst_pitch);
		end
	end

	always_comb begin
		push_cmd.is_pix = (type_s4 == REQ_PIXEL);
		push_cmd.empty = empty_s4;
		push_cmd.cw = cw_s4;
		push_cmd.ch = ch_s4;
		push_cmd.pixel = pix_s4;
		push_addr = ADDR_BITS'(cfg.frame_base) + ADDR_BITS'({prod_s4, 1'b0})
			+ ADDR_BITS'({ox_s4, 1'b0});
	end

	a_rect_size_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && type_s4 == REQ_RECT && !empty_s4) |-> (cw_s4 != '0 && ch_s4 != '0))
		else $error("non-empty rect with zero clipped size");

endmodule

[sv/crpd_queue.sv]
module crpd_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = crpd_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] wr_data,
	output logic full,
	input logic pop,
	output logic [WIDTH-1:0] rd_data,
	output logic empty
);
	import crpd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign full = (count_q == CNTW'(DEPTH));
	assign empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(DEPTH))
		else $error("queue occupancy beyond depth");

endmodule

[sv/crpd_back.sv]
module crpd_back #(
	parameter int ADDR_BITS = crpd_pkg::ADDR_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic [crpd_pkg::PITCH_W-1:0] dst_pitch,
	input logic q_empty,
	input crpd_pkg::crpd_cmd_t q_cmd,
	input logic [ADDR_BITS-1:0] q_addr,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output logic kind,
	output logic status,
	output logic [crpd_pkg::COORD_W-1:0] clipped_w,
	output logic [crpd_pkg::COORD_W-1:0] clipped_h,
	output logic [crpd_pkg::DST_W-1:0] dst_addr,
	output logic [crpd_pkg::PIX_W-1:0] pixel_out,
	output logic last,
	output logic rect_done
);
	import crpd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_W1 = 4'b0010,
		ST_W2 = 4'b0100,
		ST_W3 = 4'b1000
	} crpd_state_t;

	crpd_state_t state_q;
	logic out_valid_q;
	logic active_q;
	logic [COORD_W-1:0] clip_w_q, clip_h_q, col_q, row_q;
	logic [ADDR_BITS-1:0] row_addr_q, cur_a_q;

	logic slot_free;
	logic [ADDR_BITS-1:0] pix_a, ph_addr;
	logic [COORD_W:0] col_inc, row_inc;
	logic row_end, rect_end;
	logic [PITCH_W:0] off;

	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || !out_stall;
	assign pop = slot_free && (state_q == ST_IDLE) && !q_empty;

	assign pix_a = row_addr_q + ADDR_BITS'({col_q, 1'b0});
	assign col_inc = {1'b0, col_q} + 1'b1;
	assign row_inc = {1'b0, row_q} + 1'b1;
	assign row_end = (col_inc >= {1'b0, clip_w_q});
	assign rect_end = row_end && (row_inc >= {1'b0, clip_h_q});
	assign ph_addr = cur_a_q + ADDR_BITS'(off);

	// The 2x2 block is written left, right, then the same pair one row down.
	always_comb begin
		case (state_q)
			ST_W1: off = (PITCH_W+1)'(1);
			ST_W2: off = {1'b0, dst_pitch};
			ST_W3: off = {1'b0, dst_pitch} + 1'b1;
			default: off = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			active_q <= 1'b0;
			clip_w_q <= '0;
			clip_h_q <= '0;
			col_q <= '0;
			row_q <= '0;
			row_addr_q <= '0;
		end else if (slot_free) begin
			case (state_q)
				ST_IDLE: begin
					if (q_empty) begin
						out_valid_q <= 1'b0;
					end else if (!q_cmd.is_pix) begin
						out_valid_q <= 1'b1;
						active_q <= !q_cmd.empty;
						clip_w_q <= q_cmd.cw;
						clip_h_q <= q_cmd.ch;
						col_q <= '0;
						row_q <= '0;
						row_addr_q <= q_addr;
					end else if (active_q) begin
						out_valid_q <= 1'b1;
						state_q <= ST_W1;
						if (row_end) begin
							col_q <= '0;
							row_q <= row_inc[COORD_W-1:0];
							row_addr_q <= row_addr_q + ADDR_BITS'({dst_pitch, 1'b0});
							if (rect_end) begin
								active_q <= 1'b0;
							end
						end else begin
							col_q <= col_inc[COORD_W-1:0];
						end
					end else begin
						out_valid_q <= 1'b0;
					end
				end
				ST_W1: begin
					out_valid_q <= 1'b1;
					state_q <= ST_W2;
				end
				ST_W2: begin
					out_valid_q <= 1'b1;
					state_q <= ST_W3;
				end
				ST_W3: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					out_valid_q <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (state_q == ST_IDLE) begin
				if (!q_empty && !q_cmd.is_pix) begin
					kind <= KIND_STATUS;
					status <= q_cmd.empty ? STATUS_EMPTY : STATUS_OK;
					clipped_w <= q_cmd.empty ? '0 : q_cmd.cw;
					clipped_h <= q_cmd.empty ? '0 : q_cmd.ch;
					dst_addr <= '0;
					pixel_out <= '0;
					last <= 1'b1;
					rect_done <= 1'b0;
				end else if (!q_empty && active_q) begin
					kind <= KIND_WRITE;
					status <= STATUS_OK;
					clipped_w <= clip_w_q;
					clipped_h <= clip_h_q;
					dst_addr <= DST_W'(pix_a);
					pixel_out <= q_cmd.pixel;
					last <= 1'b0;
					rect_done <= rect_end;
					cur_a_q <= pix_a;
				end
			end else begin
				dst_addr <= DST_W'(ph_addr);
				last <= (state_q == ST_W3);
			end
		end
	end

	a_busy_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> out_valid_q)
		else $error("write sequence running with empty output register");

	a_position_in_rect: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (row_q < clip_h_q && col_q < clip_w_q))
		else $error("raster position outside the clipped rect");

endmodule

[sv/clipped_rect_pixel_doubler_unit.sv]
// The write sequencer issues one result per cycle while out_stall is low: a pixel inside
// an active rect gives four write results (the 2x2 block) and a rect command one status result.
// The front end accepts one word per cycle unless its last stage holds a word and the
// four-entry queue is full.
// Reset is asynchronous and active low; it empties the pipeline, the queue and the
// sequencer and loads the default configuration registers.
module clipped_rect_pixel_doubler_unit #(
	parameter int ADDR_BITS = crpd_pkg::ADDR_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [crpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [crpd_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic req_type,
	input logic signed [crpd_pkg::REQ_W-1:0] rect_x,
	input logic signed [crpd_pkg::REQ_W-1:0] rect_y,
	input logic signed [crpd_pkg::REQ_W-1:0] rect_w,
	input logic signed [crpd_pkg::REQ_W-1:0] rect_h,
	input logic [crpd_pkg::PIX_W-1:0] pixel_in,
	output logic out_valid,
	input logic out_stall,
	output logic kind,
	output logic status,
	output logic [crpd_pkg::COORD_W-1:0] clipped_w,
	output logic [crpd_pkg::COORD_W-1:0] clipped_h,
	output logic [crpd_pkg::DST_W-1:0] dst_addr,
	output logic [crpd_pkg::PIX_W-1:0] pixel_out,
	output logic last,
	output logic rect_done
);
	import crpd_pkg::*;

	localparam int CMD_W = $bits(crpd_cmd_t);
	localparam int QW = ADDR_BITS + CMD_W;

	crpd_cfg_t cfg_q;

	logic push, q_full, q_empty, pop;
	crpd_cmd_t push_cmd, q_cmd;
	logic [ADDR_BITS-1:0] push_addr, q_addr;
	logic [QW-1:0] q_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width <= SRC_WIDTH_RST;
			cfg_q.content_height <= CONTENT_HEIGHT_RST;
			cfg_q.dst_pitch <= DST_PITCH_RST;
			cfg_q.frame_base <= FRAME_BASE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_WIDTH: cfg_q.src_width <= cfg_data[COORD_W-1:0];
				REG_CONTENT_HEIGHT: cfg_q.content_height <= cfg_data[COORD_W-1:0];
				REG_DST_PITCH: cfg_q.dst_pitch <= cfg_data[PITCH_W-1:0];
				REG_FRAME_BASE: cfg_q.frame_base <= cfg_data[BASE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	crpd_front #(
		.ADDR_BITS(ADDR_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.rect_x(rect_x),
		.rect_y(rect_y),
		.rect_w(rect_w),
		.rect_h(rect_h),
		.pixel_in(pixel_in),
		.push(push),
		.push_cmd(push_cmd),
		.push_addr(push_addr),
		.q_full(q_full)
	);

	crpd_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_data({push_addr, push_cmd}),
		.full(q_full),
		.pop(pop),
		.rd_data(q_rd),
		.empty(q_empty)
	);

	assign q_addr = q_rd[QW-1 -: ADDR_BITS];
	assign q_cmd = crpd_cmd_t'(q_rd[CMD_W-1:0]);

	crpd_back #(
		.ADDR_BITS(ADDR_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.dst_pitch(cfg_q.dst_pitch),
		.q_empty(q_empty),
		.q_cmd(q_cmd),
		.q_addr(q_addr),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.status(status),
		.clipped_w(clipped_w),
		.clipped_h(clipped_h),
		.dst_addr(dst_addr),
		.pixel_out(pixel_out),
		.last(last),
		.rect_done(rect_done)
	);

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

import crpd_pkg::*;

localparam int unsigned ADDR_MASK = (32'd1 << ADDR_BITS_DEF) - 32'd1;

typedef struct packed {
	logic kind;
	logic status;
	logic [COORD_W-1:0] cw;
	logic [COORD_W-1:0] ch;
	logic [DST_W-1:0] addr;
	logic [PIX_W-1:0] pix;
	logic last;
	logic done;
} blit_result_t;

class blit_scoreboard;
	int unsigned src_width, content_height, dst_pitch, frame_base;
	bit active;
	int unsigned org_x, org_y, clip_w, clip_h, col_count, row_count, row_addr;
	blit_result_t expected_q[$];
	int errors, checked, words, rects, empty_rects, rects_done, pixels, ignored;

	function new();
		src_width = 32'(SRC_WIDTH_RST);
		content_height = 32'(CONTENT_HEIGHT_RST);
		dst_pitch = 32'(DST_PITCH_RST);
		frame_base = 32'(FRAME_BASE_RST);
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_SRC_WIDTH: src_width = 32'(data[COORD_W-1:0]);
			REG_CONTENT_HEIGHT: content_height = 32'(data[COORD_W-1:0]);
			REG_DST_PITCH: dst_pitch = 32'(data[PITCH_W-1:0]);
			REG_FRAME_BASE: frame_base = 32'(data[BASE_W-1:0]);
			default: ;
		endcase
	endfunction

	function void flag(string msg);
		errors++;
		if (errors <= 10) $display("%s", msg);
	endfunction

	function string show(blit_result_t r);
		return $sformatf("kind=%0d status=%0d w=%0d h=%0d addr=%06h pix=%02h last=%0d done=%0d",
			r.kind, r.status, r.cw, r.ch, r.addr, r.pix, r.last, r.done);
	endfunction

	function void push(logic k, logic st, int unsigned cw, int unsigned ch, int unsigned addr,
			logic [PIX_W-1:0] pix, logic lst, logic dn);
		blit_result_t e;
		e.kind = k;
		e.status = st;
		e.cw = COORD_W'(cw);
		e.ch = COORD_W'(ch);
		e.addr = DST_W'(addr & ADDR_MASK);
		e.pix = pix;
		e.last = lst;
		e.done = dn;
		expected_q.push_back(e);
	endfunction

	function void note_word(logic rt, logic signed [REQ_W-1:0] rx, logic signed [REQ_W-1:0] ry,
			logic signed [REQ_W-1:0] rw, logic signed [REQ_W-1:0] rh, logic [PIX_W-1:0] pix);
		int x, y, w, h;
		int unsigned a;
		logic dn;
		words++;
		if (rt == REQ_RECT) begin
			rects++;
			x = rx;
			y = ry;
			w = rw;
			h = rh;
			if (x < 0) begin
				w += x;
				x = 0;
			end
			if (y < 0) begin
				h += y;
				y = 0;
			end
			if (x + w > int'(src_width)) w = int'(src_width) - x;
			if (y + h > int'(content_height)) h = int'(content_height) - y;
			if (w <= 0 || h <= 0) begin
				active = 0;
				empty_rects++;
				push(KIND_STATUS, STATUS_EMPTY, 0, 0, 0, 8'h00, 1'b1, 1'b0);
				return;
			end
			org_x = x;
			org_y = y;
			clip_w = w;
			clip_h = h;
			col_count = 0;
			row_count = 0;
			row_addr = (frame_base + 2 * org_y * dst_pitch + 2 * org_x) & ADDR_MASK;
			active = 1;
			push(KIND_STATUS, STATUS_OK, clip_w, clip_h, 0, 8'h00, 1'b1, 1'b0);
			return;
		end
		if (!active) begin
			ignored++;
			return;
		end
		pixels++;
		a = (row_addr + 2 * col_count) & ADDR_MASK;
		dn = 1'b0;
		col_count++;
		if (col_count >= clip_w) begin
			col_count = 0;
			row_count++;
			row_addr = (row_addr + 2 * dst_pitch) & ADDR_MASK;
			if (row_count >= clip_h) begin
				active = 0;
				dn = 1'b1;
				rects_done++;
			end
		end
		push(KIND_WRITE, STATUS_OK, clip_w, clip_h, a, pix, 1'b0, dn);
		push(KIND_WRITE, STATUS_OK, clip_w, clip_h, a + 1, pix, 1'b0, dn);
		push(KIND_WRITE, STATUS_OK, clip_w, clip_h, a + dst_pitch, pix, 1'b0, dn);
		push(KIND_WRITE, STATUS_OK, clip_w, clip_h, a + dst_pitch + 1, pix, 1'b1, dn);
	endfunction

	function void check_result(blit_result_t got);
		blit_result_t e;
		checked++;
		if (expected_q.size() == 0) begin
			flag({"unexpected result: ", show(got)});
			return;
		end
		e = expected_q.pop_front();
		if (got.kind !== e.kind || got.status !== e.status || got.cw !== e.cw ||
				got.ch !== e.ch || got.addr !== e.addr || got.pix !== e.pix ||
				got.last !== e.last || got.done !== e.done)
			flag({$sformatf("mismatch on result %0d\n  expected ", checked), show(e),
				"\n  actual   ", show(got)});
	endfunction

	function void flush_missing();
		while (expected_q.size() != 0)
			flag({"missing result: ", show(expected_q.pop_front())});
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function int unsigned pixels_left();
		if (!active) return 0;
		return clip_w * clip_h - row_count * clip_w - col_count;
	endfunction
endclass

module testbench;

	localparam int IDLE_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic req_type;
	logic signed [REQ_W-1:0] rect_x;
	logic signed [REQ_W-1:0] rect_y;
	logic signed [REQ_W-1:0] rect_w;
	logic signed [REQ_W-1:0] rect_h;
	logic [PIX_W-1:0] pixel_in;
	logic out_valid;
	logic out_stall;
	logic kind;
	logic status;
	logic [COORD_W-1:0] clipped_w;
	logic [COORD_W-1:0] clipped_h;
	logic [DST_W-1:0] dst_addr;
	logic [PIX_W-1:0] pixel_out;
	logic last;
	logic rect_done;

	blit_scoreboard board;
	bit no_idle;
	int stall_hold;
	int stall_len;
	int idle_cycles;
	int settings;

	clipped_rect_pixel_doubler_unit u_top (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle) return 0;
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold = stall_hold - 1;
		end else begin
			stall_len = pick_gap();
			if (stall_len == 0) begin
				out_stall <= 1'b0;
				stall_hold = $urandom_range(0, 4);
			end else begin
				out_stall <= 1'b1;
				stall_hold = stall_len - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result('{kind, status, clipped_w, clipped_h, dst_addr, pixel_out,
				last, rect_done});
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no word moved for %0d cycles, %0d results outstanding",
					IDLE_LIMIT, board.pending());
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic send_word(input logic rt, input logic [REQ_W-1:0] x, input logic [REQ_W-1:0] y,
			input logic [REQ_W-1:0] w, input logic [REQ_W-1:0] h, input logic [PIX_W-1:0] pix);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		rect_x <= x;
		rect_y <= y;
		rect_w <= w;
		rect_h <= h;
		pixel_in <= pix;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_word(rt, x, y, w, h, pix);
	endtask

	task automatic send_rect(input int x, input int y, input int w, input int h);
		send_word(REQ_RECT, REQ_W'(x), REQ_W'(y), REQ_W'(w), REQ_W'(h), PIX_W'($urandom));
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] pix);
		send_word(REQ_PIXEL, REQ_W'($urandom), REQ_W'($urandom), REQ_W'($urandom),
			REQ_W'($urandom), pix);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(data);
		@(posedge clk);
		board.set_reg(idx, CFG_DATA_W'(data));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int unsigned sw, input int unsigned ch, input int unsigned pitch,
			input int unsigned base);
		drain();
		write_reg(REG_SRC_WIDTH, sw);
		write_reg(REG_CONTENT_HEIGHT, ch);
		write_reg(REG_DST_PITCH, pitch);
		write_reg(REG_FRAME_BASE, base);
		settings++;
	endtask

	function automatic int unsigned random_bound(input int unsigned hi, input int unsigned lo);
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return $urandom_range(lo, lo + 11);
		if (r < 80) return $urandom_range(lo + 12, 400);
		if (r < 95) return ($urandom_range(0, 1) != 0) ? hi : $urandom_range(lo, hi);
		return $urandom;
	endfunction

	task automatic random_configure();
		drain();
		if ($urandom_range(0, 3) != 0) write_reg(REG_SRC_WIDTH, random_bound(4096, 1));
		if ($urandom_range(0, 3) != 0) write_reg(REG_CONTENT_HEIGHT, random_bound(4096, 1));
		if ($urandom_range(0, 3) != 0) write_reg(REG_DST_PITCH, random_bound(8192, 2));
		if ($urandom_range(0, 3) != 0) write_reg(REG_FRAME_BASE, $urandom);
		settings++;
	endtask

	function automatic int pick_origin(input int bound);
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, bound);
			1: return bound - int'($urandom_range(0, 6));
			2: return -int'($urandom_range(1, 5));
			default: return $urandom_range(0, (bound < 8) ? bound : 8);
		endcase
	endfunction

	task automatic send_shaped_rect();
		int sw, chh, x, y, w, h;
		sw = board.src_width;
		chh = board.content_height;
		x = pick_origin(sw);
		y = pick_origin(chh);
		w = $urandom_range(1, 6);
		h = $urandom_range(1, 4);
		if (sw <= 16 && $urandom_range(0, 9) == 0) w = $urandom_range(7, 32767);
		if (chh <= 16 && $urandom_range(0, 9) == 0) h = $urandom_range(5, 32767);
		send_rect(x, y, w, h);
	endtask

	task automatic random_phase(input int budget);
		int n, r, want;
		n = 0;
		while (n < budget) begin
			r = $urandom_range(0, 99);
			no_idle = ($urandom_range(0, 4) == 0);
			if (board.active && r < 70) begin
				want = board.pixels_left();
				if (want > 30) want = $urandom_range(1, 30);
				if (want > budget - n) want = budget - n;
				repeat (want) send_pixel(PIX_W'($urandom));
				n += want;
			end else if (r < 78) begin
				send_pixel(PIX_W'($urandom));
				n++;
			end else if (r < 88) begin
				send_rect($urandom, $urandom, $urandom, $urandom);
				n++;
			end else if (r < 90) begin
				drain();
			end else begin
				send_shaped_rect();
				n++;
				want = board.pixels_left();
				if (want > 40) want = 40;
				if (want > 0 && $urandom_range(0, 99) < 15) want = $urandom_range(0, want - 1);
				if (want > budget - n) want = budget - n;
				repeat (want) send_pixel(PIX_W'($urandom));
				n += want;
			end
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = REQ_RECT;
		rect_x = '0;
		rect_y = '0;
		rect_w = '0;
		rect_h = '0;
		pixel_in = '0;
		out_stall = 1'b0;
		no_idle = 1'b0;
		stall_hold = 0;
		idle_cycles = 0;
		settings = 1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pixel(8'hFF);
		send_rect(0, 0, 2, 2);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'h80);
		send_pixel(8'h7F);
		send_pixel(8'h01);
		send_rect(-3, -2, 5, 4);
		send_pixel(8'hAA);
		send_pixel(8'h55);
		send_rect(318, 199, 10, 10);
		send_pixel(8'hC3);
		send_pixel(8'h3C);
		send_rect(32767, 32767, 32767, 32767);
		send_rect(-32768, -32768, -32768, -32768);
		send_rect(0, 0, 0, 5);
		send_rect(0, 0, 5, -1);
		send_pixel(8'h33);
		send_rect(-32768, 0, 32767, 1);
		send_rect(-1, -1, 32767, 32767);
		send_pixel(8'h12);
		send_pixel(8'hED);
		send_rect(319, 199, 1, 1);
		send_pixel(8'h99);
		send_rect(5, 5, 3, 3);
		send_pixel(8'h5A);
		send_pixel(8'hA5);

		configure(0, 4096, 8192, 22'h3FFFFF);
		random_phase(12);
		configure(4, 3, 2, 22'h3FFFFF);
		random_phase(40);
		configure(4096, 4096, 3, 22'h3FFF00);
		random_phase(40);
		configure(1, 0, 640, 0);
		random_phase(10);
		configure(1, 1, 2, 0);
		random_phase(25);
		repeat (5) begin
			random_configure();
			random_phase(31);
		end

		drain();
		repeat (20) @(posedge clk);
		board.flush_missing();
		$display("Ran %0d words over %0d register settings: %0d rects (%0d empty, %0d finished),",
			board.words, settings, board.rects, board.empty_rects, board.rects_done);
		$display("%0d pixels doubled, %0d pixels ignored, %0d results checked, %0d errors.",
			board.pixels, board.ignored, board.checked, board.errors);
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[clipped_rect_pixel_doubler_unit.f]
sv/crpd_pkg.sv
sv/crpd_front.sv
sv/crpd_queue.sv
sv/crpd_back.sv
sv/clipped_rect_pixel_doubler_unit.sv
tb/testbench.sv
